[rtl/lgwd_pkg.sv]
// Package for the light gun window detect unit.
// Holds field widths, register indexes, luma weights and bounds.
// No dependencies; used by light_gun_window_detect_unit.
package lgwd_pkg;

  // Field widths
  localparam int unsigned PixW    = 16;
  localparam int unsigned CoordW  = 10;
  localparam int unsigned SideW   = 11;
  localparam int unsigned RadW    = 4;
  localparam int unsigned ThrW    = 8;
  localparam int unsigned ChanW   = 8;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 11;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 8;

  // Weighted sum width: 255 * 1000 and 256 * 1000 both fit in 18 bits
  localparam int unsigned LumaSumW = 18;

  // Bounds on screen side and window radius
  localparam logic [SideW-1:0] MaxSide   = SideW'(1024);
  localparam logic [RadW-1:0]  MaxRadius = RadW'(15);

  // Reset values of the configuration registers
  localparam logic [SideW-1:0] ResetWidth  = SideW'(256);
  localparam logic [SideW-1:0] ResetHeight = SideW'(240);
  localparam logic [RadW-1:0]  ResetRadius = RadW'(2);
  localparam logic [ThrW-1:0]  ResetThr    = ThrW'(128);

  // Luma weights and divisor
  localparam logic [LumaSumW-1:0] CoefR   = LumaSumW'(299);
  localparam logic [LumaSumW-1:0] CoefG   = LumaSumW'(587);
  localparam logic [LumaSumW-1:0] CoefB   = LumaSumW'(114);
  localparam logic [LumaSumW-1:0] LumaDiv = LumaSumW'(1000);

  // Configuration register indexes
  typedef enum logic [CfgAddrW-1:0] {
    REG_AIM_X     = 3'd0,
    REG_AIM_Y     = 3'd1,
    REG_SCR_W     = 3'd2,
    REG_SCR_H     = 3'd3,
    REG_RADIUS    = 3'd4,
    REG_THRESHOLD = 3'd5
  } cfg_reg_t;

  // One input pixel as held in the input register
  typedef struct packed {
    logic [PixW-1:0]   rgb;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic              last;
  } pixel_t;

endpackage

[rtl/light_gun_window_detect_unit.sv]
// Top level of the light gun window detect unit.
// Input register, window test, luma compare, sticky flag, output register.
// Depends on lgwd_pkg.
//
// Usage:
//   in_*  : one RGB565 pixel per transfer with its column and row in
//           in_tdata; in_tlast marks the frame-end pixel.
//   out_* : one transfer per frame-end pixel, out_tdata[0] = 1 when any
//           pixel inside the square window around the aim point had a
//           luma strictly above the threshold during that frame.
//   cfg_* : write-only registers (aim point, screen size, radius,
//           threshold), written while no pixel is in flight.
// Throughput is one pixel per cycle unless a frame-end pixel stalls:
// the window test and the weighted luma sum run between the input register
// and the result register, where a frame-end pixel raises out_tvalid.
// Reset clears both pipeline valids and the sticky flag and loads the
// register defaults. While out_tvalid waits for out_tready, pixels that
// are not frame-end keep flowing; a second frame-end pixel stalls in the
// input register until the pending result is taken.
module light_gun_window_detect_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  // tdata: pixel_rgb565 [15:0], pixel_x [25:16], pixel_y [35:26], zero fill
  input  logic [lgwd_pkg::InDataW-1:0]      in_tdata,
  input  logic                              in_tlast,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // tdata: light_detected [0], zero fill
  output logic [lgwd_pkg::OutDataW-1:0]     out_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_we,
  input  logic [lgwd_pkg::CfgAddrW-1:0]     cfg_addr,
  input  logic [lgwd_pkg::CfgDataW-1:0]     cfg_wdata
);

  // Configuration registers
  logic [lgwd_pkg::CoordW-1:0] aim_x_r, aim_y_r;
  logic [lgwd_pkg::SideW-1:0]  scr_w_r, scr_h_r;
  logic [lgwd_pkg::RadW-1:0]   radius_r;
  logic [lgwd_pkg::ThrW-1:0]   thr_r;

  // Pipeline state
  logic              a_valid_r;
  lgwd_pkg::pixel_t  a_pix_r;
  logic              hit_seen_r, hit_seen_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_light_r, out_light_nxt;

  // Datapath signals
  logic [lgwd_pkg::SideW-1:0]    w_cap, h_cap;
  logic [lgwd_pkg::RadW-1:0]     rad_cap;
  logic                          aim_ok, pix_ok, in_win;
  logic [lgwd_pkg::CoordW-1:0]   dx, dy;
  logic [lgwd_pkg::ChanW-1:0]    r8, g8, b8;
  logic [lgwd_pkg::LumaSumW-1:0] luma_sum, luma_lim;
  logic                          a_hit;
  logic                          out_free, a_fire, in_fire;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aim_x_r  <= '0;
      aim_y_r  <= '0;
      scr_w_r  <= lgwd_pkg::ResetWidth;
      scr_h_r  <= lgwd_pkg::ResetHeight;
      radius_r <= lgwd_pkg::ResetRadius;
      thr_r    <= lgwd_pkg::ResetThr;
    end else if (cfg_we) begin
      case (lgwd_pkg::cfg_reg_t'(cfg_addr))
        lgwd_pkg::REG_AIM_X:     aim_x_r  <= cfg_wdata[lgwd_pkg::CoordW-1:0];
        lgwd_pkg::REG_AIM_Y:     aim_y_r  <= cfg_wdata[lgwd_pkg::CoordW-1:0];
        lgwd_pkg::REG_SCR_W:     scr_w_r  <= cfg_wdata[lgwd_pkg::SideW-1:0];
        lgwd_pkg::REG_SCR_H:     scr_h_r  <= cfg_wdata[lgwd_pkg::SideW-1:0];
        lgwd_pkg::REG_RADIUS:    radius_r <= cfg_wdata[lgwd_pkg::RadW-1:0];
        lgwd_pkg::REG_THRESHOLD: thr_r    <= cfg_wdata[lgwd_pkg::ThrW-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: a frame-end pixel needs a free result slot, others pass
  assign out_free  = !out_valid_r || out_tready;
  assign a_fire    = a_valid_r && (!a_pix_r.last || out_free);
  assign in_tready = !a_valid_r || a_fire;
  assign in_fire   = in_tvalid && in_tready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_tready) begin
      a_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_pix_r.rgb  <= in_tdata[15:0];
      a_pix_r.x    <= in_tdata[25:16];
      a_pix_r.y    <= in_tdata[35:26];
      a_pix_r.last <= in_tlast;
    end
  end

  // Bound screen size and radius
  always_comb begin
    w_cap   = (scr_w_r > lgwd_pkg::MaxSide) ? lgwd_pkg::MaxSide : scr_w_r;
    h_cap   = (scr_h_r > lgwd_pkg::MaxSide) ? lgwd_pkg::MaxSide : scr_h_r;
    rad_cap = (radius_r > lgwd_pkg::MaxRadius) ? lgwd_pkg::MaxRadius : radius_r;
  end

  // Window test
  always_comb begin
    aim_ok = ({1'b0, aim_x_r} < w_cap) && ({1'b0, aim_y_r} < h_cap);
    pix_ok = ({1'b0, a_pix_r.x} < w_cap) && ({1'b0, a_pix_r.y} < h_cap);
    dx = (a_pix_r.x >= aim_x_r) ? (a_pix_r.x - aim_x_r) : (aim_x_r - a_pix_r.x);
    dy = (a_pix_r.y >= aim_y_r) ? (a_pix_r.y - aim_y_r) : (aim_y_r - a_pix_r.y);
    in_win = (dx <= lgwd_pkg::CoordW'(rad_cap)) && (dy <= lgwd_pkg::CoordW'(rad_cap));
  end

  // Expand channels and compare luma: floor(sum/1000) > thr <=> sum >= (thr+1)*1000
  always_comb begin
    r8 = {a_pix_r.rgb[15:11], a_pix_r.rgb[15:13]};
    g8 = {a_pix_r.rgb[10:5],  a_pix_r.rgb[10:9]};
    b8 = {a_pix_r.rgb[4:0],   a_pix_r.rgb[4:2]};
    luma_sum = lgwd_pkg::LumaSumW'(r8) * lgwd_pkg::CoefR
             + lgwd_pkg::LumaSumW'(g8) * lgwd_pkg::CoefG
             + lgwd_pkg::LumaSumW'(b8) * lgwd_pkg::CoefB;
    luma_lim = (lgwd_pkg::LumaSumW'(thr_r) + lgwd_pkg::LumaSumW'(1)) * lgwd_pkg::LumaDiv;
    a_hit = aim_ok && pix_ok && in_win && (luma_sum >= luma_lim);
  end

  // Sticky flag and result slot
  always_comb begin
    hit_seen_nxt  = hit_seen_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_light_nxt = out_light_r;
    if (a_fire) begin
      if (a_pix_r.last) begin
        out_valid_nxt = 1'b1;
        out_light_nxt = hit_seen_r || a_hit;
        hit_seen_nxt  = 1'b0;
      end else begin
        hit_seen_nxt  = hit_seen_r || a_hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_seen_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      hit_seen_r  <= hit_seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_light_r <= out_light_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(lgwd_pkg::OutDataW-1){1'b0}}, out_light_r};

  // Checks
  a_last_clears_flag: assert property (@(posedge clk) disable iff (!rst_n)
    a_fire && a_pix_r.last |=> !hit_seen_r)
    else $error("sticky flag not cleared after frame end");

  a_last_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
    a_fire && a_pix_r.last |=> out_valid_r && (out_light_r == $past(hit_seen_r || a_hit)))
    else $error("frame-end result not loaded with the flag");

  a_last_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    a_fire && a_pix_r.last |-> !out_valid_r || out_tready)
    else $error("frame-end pixel advanced over a pending result");

  a_flag_kept: assert property (@(posedge clk) disable iff (!rst_n)
    a_fire && !a_pix_r.last && hit_seen_r |=> hit_seen_r)
    else $error("sticky flag dropped inside a frame");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> a_valid_r && a_pix_r.last && out_valid_r && !out_tready)
    else $error("input stalled without a blocked frame-end pixel");

endmodule
